[rtl/qdd_pkg.sv]
// qdd_pkg: shared types, constants and helpers for the quadrature detent decoder
// holds the gray-code step table and the detent threshold clamp
// no dependencies
`timescale 1ns / 1ps

package qdd_pkg;

   // field widths
   localparam int unsigned PinsWidth   = 2;
   localparam int unsigned StepWidth   = 2;
   localparam int unsigned AccumWidth  = 5;
   localparam int unsigned DetentWidth = 4;

   // detent threshold limits and reset values
   localparam logic [DetentWidth-1:0] DetentMin   = 4'd1;
   localparam logic [DetentWidth-1:0] DetentMax   = 4'd8;
   localparam logic [DetentWidth-1:0] DetentReset = 4'd4;
   localparam logic [PinsWidth-1:0]   PinsReset   = 2'b11;

   typedef logic signed [StepWidth-1:0]  step_type;
   typedef logic signed [AccumWidth-1:0] accum_type;
   typedef logic [DetentWidth-1:0]       detent_type;
   typedef logic [PinsWidth-1:0]         pins_type;

   // step codes
   localparam step_type StepNone = 2'sb00;
   localparam step_type StepFwd  = 2'sb01;
   localparam step_type StepBack = 2'sb11;

   // x4 gray-code transition table, index is {old pins, new pins}
   function automatic step_type gray_step(input logic [3:0] idx);
      step_type s;
      unique case (idx)
         4'd1, 4'd7, 4'd8, 4'd14:  s = StepBack;
         4'd2, 4'd4, 4'd11, 4'd13: s = StepFwd;
         default:                  s = StepNone;
      endcase
      return s;
   endfunction

   // register value clamped into the usable detent range
   function automatic detent_type clamp_detent(input detent_type raw);
      detent_type t;
      priority if (raw < DetentMin) begin
         t = DetentMin;
      end else if (raw > DetentMax) begin
         t = DetentMax;
      end else begin
         t = raw;
      end
      return t;
   endfunction

endpackage

[rtl/quadrature_detent_decoder.sv]
// quadrature_detent_decoder: x4 quadrature decoder with detent grouping
// one state update per item, result held in an output register
// depends on qdd_pkg
`timescale 1ns / 1ps

//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  req     | req_valid/ready, pin_a, pin_b, take_next/prev | in
//  rsp     | rsp_valid/ready, step_dir, position_accum,     | out
//          | next_pending, prev_pending                     |
//  csr     | csr_write_en, csr_write_data                   | in
//
//  one item per cycle while no result is stalled; the result appears in the cycle after the item is taken
//  state (pins, accumulator, flags) updates at the edge that takes the item
//  req_ready is low only while a result waits and rsp_ready is low
//  synchronous reset: pins to both high, accumulator and flags to zero, threshold 4

module quadrature_detent_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_pin_a,
   input  logic                req_pin_b,
   input  logic                req_take_next,
   input  logic                req_take_prev,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output qdd_pkg::step_type   rsp_step_dir,
   output qdd_pkg::accum_type  rsp_position_accum,
   output logic                rsp_next_pending,
   output logic                rsp_prev_pending,
   input  logic                csr_write_en,
   input  qdd_pkg::detent_type csr_write_data
);
   import qdd_pkg::*;

   detent_type detent_ff;
   pins_type   last_pins_ff, last_pins_in;
   accum_type  accum_ff, accum_in;
   logic       next_flag_ff, next_flag_in;
   logic       prev_flag_ff, prev_flag_in;

   logic       rsp_valid_ff;
   step_type   rsp_step_ff, rsp_step_in;
   accum_type  rsp_accum_ff;
   logic       rsp_next_ff, rsp_next_in;
   logic       rsp_prev_ff, rsp_prev_in;

   logic       accept;
   pins_type   pins;
   accum_type  sum;
   accum_type  thr_pos;
   accum_type  thr_neg;

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // step decode, accumulate and detent check
   always_comb begin
      pins        = {req_pin_a, req_pin_b};
      rsp_step_in = gray_step({last_pins_ff, pins});
      thr_pos     = accum_type'({1'b0, clamp_detent(detent_ff)});
      thr_neg     = -thr_pos;
      sum         = accum_ff + accum_type'(rsp_step_in);
      accum_in    = accum_ff;
      rsp_next_in = next_flag_ff;
      rsp_prev_in = prev_flag_ff;
      if (rsp_step_in != StepNone) begin
         priority if (sum >= thr_pos) begin
            rsp_next_in = 1'b1;
            accum_in    = '0;
         end else if (sum <= thr_neg) begin
            rsp_prev_in = 1'b1;
            accum_in    = '0;
         end else begin
            accum_in    = sum;
         end
      end
      last_pins_in = pins;
      next_flag_in = rsp_next_in && !req_take_next;
      prev_flag_in = rsp_prev_in && !req_take_prev;
   end

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         detent_ff <= DetentReset;
      end else if (csr_write_en) begin
         detent_ff <= csr_write_data;
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_pins_ff <= PinsReset;
         accum_ff     <= '0;
         next_flag_ff <= 1'b0;
         prev_flag_ff <= 1'b0;
      end else if (accept) begin
         last_pins_ff <= last_pins_in;
         accum_ff     <= accum_in;
         next_flag_ff <= next_flag_in;
         prev_flag_ff <= prev_flag_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_step_ff  <= rsp_step_in;
         rsp_accum_ff <= accum_in;
         rsp_next_ff  <= rsp_next_in;
         rsp_prev_ff  <= rsp_prev_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_step_dir       = rsp_step_ff;
   assign rsp_position_accum = rsp_accum_ff;
   assign rsp_next_pending   = rsp_next_ff;
   assign rsp_prev_pending   = rsp_prev_ff;

   // accumulator never reaches a detent without clearing
   a_accum_range: assert property (@(posedge clock) disable iff (reset)
      (accum_ff <= accum_type'(7)) && (accum_ff >= accum_type'(-7)))
      else $error("accumulator out of range");

   // a taken item always produces a result next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("result missing after item");

   // a stalled result blocks new items
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("item taken over stalled result");

   // reported step is never the unused code
   a_step_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_step_ff == StepNone || rsp_step_ff == StepFwd ||
                        rsp_step_ff == StepBack))
      else $error("bad step code");

   // a detent that raises a pending flag clears the reported accumulator
   a_detent_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_step_in != StepNone && (rsp_next_in != next_flag_ff ||
       rsp_prev_in != prev_flag_ff)) |=> (rsp_accum_ff == '0))
      else $error("accumulator not cleared on detent");

endmodule
